[rtl/weighted_interval_scheduling_dp_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef WEIGHTED_INTERVAL_SCHEDULING_DP_TOP_DEFINES_SVH
`define WEIGHTED_INTERVAL_SCHEDULING_DP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WIS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: lbl");

// Next-cycle implication, disabled while reset is asserted.
`define WIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: lbl");

// Next-cycle implication that also holds across reset.
`define WIS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("check failed: lbl");

`endif

[rtl/wis_pkg.sv]
`default_nettype none

package wis_pkg;

    // Job store depth and derived index widths
    localparam int unsigned MAX_JOBS    = 1024;
    localparam int unsigned WIS_IDX_W   = $clog2(MAX_JOBS);
    localparam int unsigned WIS_CNT_W   = $clog2(MAX_JOBS + 1);

    // Field widths
    localparam int unsigned WIS_TIME_W  = 32;
    localparam int unsigned WIS_VALUE_W = 16;
    localparam int unsigned WIS_TOTAL_W = 26;
    localparam int unsigned WIS_SUM_W   = WIS_TOTAL_W + 1;

    // Command queue between front and back
    localparam int unsigned WIS_QDEPTH  = 2;
    localparam int unsigned WIS_QPTR_W  = $clog2(WIS_QDEPTH);
    localparam int unsigned WIS_QCNT_W  = $clog2(WIS_QDEPTH + 1);

    typedef enum logic [1:0] {
        WIS_ST_OK    = 2'd0,
        WIS_ST_ORDER = 2'd1,
        WIS_ST_FULL  = 2'd2
    } wis_status_t;

    typedef struct packed {
        logic                   first_of_set;
        logic [WIS_TIME_W-1:0]  start_time;
        logic [WIS_TIME_W-1:0]  finish_time;
        logic [WIS_VALUE_W-1:0] job_value;
    } wis_in_t;

    typedef struct packed {
        logic [WIS_TOTAL_W-1:0] best_total;
        wis_status_t            status;
    } wis_out_t;

    typedef enum logic [2:0] {
        WIS_IDLE,
        WIS_SEARCH,
        WIS_TOT_RD,
        WIS_ADD,
        WIS_FINISH,
        WIS_RESP
    } wis_state_t;

endpackage

`default_nettype wire

[rtl/weighted_interval_scheduling_dp_top.sv]
`default_nettype none

// Weighted interval scheduling, one job per transfer.
// Input channel (s_valid/s_ready/s_payload): a job with start, finish and
// value, in non-decreasing finish order; first_of_set opens a new job set.
// Result channel (m_valid/m_ready/m_payload): one result per job, in order,
// holding the best total of the set so far and a status code (ok, finish out
// of order, store full or total overflow). Rejected jobs leave the set as is.
// Jobs land in a two-entry command queue, so the input keeps taking transfers
// while the engine works and while a result waits on the output register.
// In the engine, each job runs a binary search of up to ceil(log2(n + 1))
// probes over the n stored jobs, so at most 10, since at most 1023 jobs sit
// ahead of an accepted one; rejected jobs skip the search and go straight to
// the response. The search loop runs through the single read port of the
// finish-time store. With the engine idle, the queue hand-off shares the
// engine's first cycle. A stalled result receiver holds the result register;
// the engine then waits and the queue fills, after which s_ready drops.
// Reset (aresetn low, synchronous) empties the queue, drops m_valid and
// clears the job count; the stores need no clearing.
module weighted_interval_scheduling_dp_top (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wis_pkg::wis_in_t    s_payload,
    output logic                m_valid,
    input  wire logic           m_ready,
    output wis_pkg::wis_out_t   m_payload
);
    import wis_pkg::*;

    logic    cmd_valid;
    logic    cmd_ready;
    wis_in_t cmd;

    wis_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    wis_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

[rtl/wis_front.sv]
`default_nettype none

// Input side: takes job transfers into a short command queue so the
// input stays open while the search engine is busy.
module wis_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wis_pkg::wis_in_t    s_payload,
    output logic                cmd_valid,
    input  wire logic           cmd_ready,
    output wis_pkg::wis_in_t    cmd
);
    import wis_pkg::*;

    wis_in_t               q_reg [WIS_QDEPTH];
    logic [WIS_QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [WIS_QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [WIS_QCNT_W-1:0] cnt_reg, cnt_next;
    logic                  push, pop;

    // Queue status
    assign s_ready   = (cnt_reg != WIS_QCNT_W'(WIS_QDEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == WIS_QPTR_W'(WIS_QDEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == WIS_QPTR_W'(WIS_QDEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue entries
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= s_payload;
        end
    end

endmodule

`default_nettype wire

[rtl/wis_back.sv]
`default_nettype none

// Search engine: binary search over the stored finish times, one probe
// per cycle, then the include/exclude choice and the store update.
module wis_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wis_pkg::wis_in_t    cmd,
    output logic                m_valid,
    input  wire logic           m_ready,
    output wis_pkg::wis_out_t   m_payload
);
    import wis_pkg::*;

    // Job stores
    logic [WIS_TIME_W-1:0]  finish_mem [MAX_JOBS];
    logic [WIS_TOTAL_W-1:0] total_mem  [MAX_JOBS];

    wis_state_t             state_reg, state_next;

    // Set state
    logic [WIS_CNT_W-1:0]   job_count_reg;
    logic [WIS_TIME_W-1:0]  last_finish_reg;
    logic [WIS_TOTAL_W-1:0] prev_total_reg;

    // Working item
    wis_in_t                item_reg;
    logic [WIS_CNT_W-1:0]   cnt_work_reg;
    logic [WIS_TOTAL_W-1:0] prev_work_reg;
    logic [WIS_CNT_W-1:0]   lo_reg, hi_reg;
    logic [WIS_IDX_W-1:0]   mid_reg;
    logic [WIS_TIME_W-1:0]  fin_rd_reg;
    logic [WIS_TOTAL_W-1:0] tot_rd_reg;
    logic [WIS_SUM_W-1:0]   incl_reg;
    wis_out_t               res_reg;

    // Output register
    logic                   m_valid_reg;
    wis_out_t               m_payload_reg;

    // Dispatch view of the incoming command
    logic [WIS_CNT_W-1:0]   cnt_eff;
    logic [WIS_TIME_W-1:0]  lf_eff;
    logic [WIS_TOTAL_W-1:0] prev_eff;
    logic                   order_bad, store_full, reject;

    // Search step
    logic                   go_lo;
    logic [WIS_CNT_W-1:0]   lo_n, hi_n, lo_m1;
    logic [WIS_CNT_W:0]     sum_lh;
    logic [WIS_CNT_W-1:0]   mid_full;
    logic                   search_more;

    // Finish step
    logic                   overflow;
    logic [WIS_TOTAL_W-1:0] best;

    // Control strobes
    logic                   dispatch;
    logic                   rd_en;
    logic [WIS_IDX_W-1:0]   rd_addr;
    logic                   mem_we;
    logic                   out_load;

    // Classify the command at the head of the queue
    always_comb begin
        cnt_eff    = cmd.first_of_set ? '0 : job_count_reg;
        lf_eff     = cmd.first_of_set ? '0 : last_finish_reg;
        prev_eff   = (cnt_eff == '0) ? '0 : prev_total_reg;
        order_bad  = (cnt_eff != '0) && (cmd.finish_time < lf_eff);
        store_full = (cnt_eff >= WIS_CNT_W'(MAX_JOBS));
        reject     = order_bad || store_full;
    end

    // Bounds after this cycle's probe, and the next probe point
    always_comb begin
        go_lo = (fin_rd_reg <= item_reg.start_time);
        if (state_reg == WIS_IDLE) begin
            lo_n = '0;
            hi_n = cnt_eff;
        end else if (go_lo) begin
            lo_n = WIS_CNT_W'(mid_reg) + 1'b1;
            hi_n = hi_reg;
        end else begin
            lo_n = lo_reg;
            hi_n = WIS_CNT_W'(mid_reg);
        end
        search_more = (lo_n < hi_n);
        sum_lh      = {1'b0, lo_n} + {1'b0, hi_n};
        mid_full    = sum_lh[WIS_CNT_W:1];
        lo_m1       = lo_reg - 1'b1;
    end

    // Include/exclude choice
    always_comb begin
        overflow = incl_reg[WIS_SUM_W-1];
        best     = (incl_reg[WIS_TOTAL_W-1:0] > prev_work_reg) ? incl_reg[WIS_TOTAL_W-1:0]
                                                                : prev_work_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            WIS_IDLE: begin
                if (cmd_valid) begin
                    if (reject) begin
                        state_next = WIS_RESP;
                    end else if (search_more) begin
                        state_next = WIS_SEARCH;
                    end else begin
                        state_next = WIS_TOT_RD;
                    end
                end
            end
            WIS_SEARCH: begin
                if (!search_more) begin
                    state_next = WIS_TOT_RD;
                end
            end
            WIS_TOT_RD: state_next = WIS_ADD;
            WIS_ADD:    state_next = WIS_FINISH;
            WIS_FINISH: state_next = WIS_RESP;
            WIS_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = WIS_IDLE;
                end
            end
            default:    state_next = WIS_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        cmd_ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = mid_full[WIS_IDX_W-1:0];
        mem_we    = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            WIS_IDLE: begin
                cmd_ready = 1'b1;
                rd_en     = cmd_valid && !reject && search_more;
            end
            WIS_SEARCH: begin
                rd_en = search_more;
            end
            WIS_TOT_RD: begin
                rd_en   = (lo_reg != '0);
                rd_addr = lo_m1[WIS_IDX_W-1:0];
            end
            WIS_FINISH: begin
                mem_we = !overflow;
            end
            WIS_RESP: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign dispatch  = cmd_valid && cmd_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= WIS_IDLE;
            job_count_reg   <= '0;
            last_finish_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (dispatch) begin
                job_count_reg   <= cnt_eff;
                last_finish_reg <= lf_eff;
            end else if (mem_we) begin
                job_count_reg   <= cnt_work_reg + 1'b1;
                last_finish_reg <= item_reg.finish_time;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (dispatch) begin
            item_reg      <= cmd;
            cnt_work_reg  <= cnt_eff;
            prev_work_reg <= prev_eff;
            res_reg       <= '{best_total: prev_eff,
                               status: (order_bad ? WIS_ST_ORDER : WIS_ST_FULL)};
        end
        if (state_reg == WIS_IDLE || state_reg == WIS_SEARCH) begin
            lo_reg  <= lo_n;
            hi_reg  <= hi_n;
            mid_reg <= mid_full[WIS_IDX_W-1:0];
        end
        if (state_reg == WIS_ADD) begin
            incl_reg <= WIS_SUM_W'(item_reg.job_value)
                      + ((lo_reg != '0) ? WIS_SUM_W'(tot_rd_reg) : '0);
        end
        if (state_reg == WIS_FINISH) begin
            if (overflow) begin
                res_reg <= '{best_total: prev_work_reg, status: WIS_ST_FULL};
            end else begin
                res_reg        <= '{best_total: best, status: WIS_ST_OK};
                prev_total_reg <= best;
            end
        end
        if (out_load) begin
            m_payload_reg <= res_reg;
        end
    end

    // Job store port: one registered read, one write, never in the same cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            finish_mem[cnt_work_reg[WIS_IDX_W-1:0]] <= item_reg.finish_time;
            total_mem[cnt_work_reg[WIS_IDX_W-1:0]]  <= best;
        end
        if (rd_en) begin
            fin_rd_reg <= finish_mem[rd_addr];
            tot_rd_reg <= total_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/wis_checker.sv]
`default_nettype none
`include "weighted_interval_scheduling_dp_top_defines.svh"

// Port-level checks on the top level.
module wis_checker (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           s_ready,
    input  wis_pkg::wis_in_t    s_payload,
    input  wire logic           m_valid,
    input  wire logic           m_ready,
    input  wis_pkg::wis_out_t   m_payload
);
    import wis_pkg::*;

    wis_in_t unused_in;
    assign unused_in = s_payload;

    // Reset empties everything, and no result can appear the cycle after
    `WIS_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, (!m_valid && s_ready) ##1 !m_valid)

    // A stalled result holds
    `WIS_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))

    // The queue only fills up on an input transfer
    `WIS_ASSERT_IMPL(a_full_after_push, aclk, aresetn, $fell(s_ready), $past(s_valid))

endmodule

bind weighted_interval_scheduling_dp_top wis_checker u_wis_checker (.*);

`default_nettype wire

[tb/sv/weighted_interval_scheduling_dp_top_test.sv]
`timescale 1ns / 100ps

module weighted_interval_scheduling_dp_top_test;

    import wis_pkg::*;

    localparam logic [31:0] TOTAL_CEIL = (32'd1 << WIS_TOTAL_W) - 32'd1;
    localparam int unsigned RANDOM_JOBS = 829;
    localparam int unsigned DRAIN_CYCLES = 40;

    // One row of the directed stimulus; want is used only where typed is set
    typedef struct {
        wis_in_t  job;
        bit       typed;
        wis_out_t want;
    } demo_row_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    wis_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    wis_out_t m_payload;

    weighted_interval_scheduling_dp_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Shadow copy of the job set
    logic [WIS_TIME_W-1:0]  sched_finish [MAX_JOBS];
    logic [WIS_TOTAL_W-1:0] sched_total  [MAX_JOBS];
    int unsigned            sched_count = 0;
    logic [WIS_TIME_W-1:0]  sched_last = '0;

    wis_out_t    due_results [$];
    demo_row_t   demo_rows [$];
    int unsigned fault_count = 0;
    int unsigned jobs_sent = 0;
    int unsigned ok_seen = 0;
    int unsigned order_seen = 0;
    int unsigned full_seen = 0;
    int unsigned burst_left = 0;

    // Best total after one job, updating the shadow set
    function automatic wis_out_t schedule_job(input wis_in_t job);
        wis_out_t    r;
        logic [31:0] incl;
        logic [WIS_TOTAL_W-1:0] prior;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        if (job.first_of_set) begin
            sched_count = 0;
            sched_last  = '0;
        end
        prior = (sched_count != 0) ? sched_total[sched_count-1] : '0;
        r.best_total = prior;
        if (sched_count != 0 && job.finish_time < sched_last) begin
            r.status = WIS_ST_ORDER;
            return r;
        end
        if (sched_count >= MAX_JOBS) begin
            r.status = WIS_ST_FULL;
            return r;
        end
        // count of stored finishes at or before the start
        lo = 0;
        hi = sched_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (sched_finish[mid] <= job.start_time) lo = mid + 1;
            else hi = mid;
        end
        incl = 32'(job.job_value);
        if (lo != 0) incl = incl + 32'(sched_total[lo-1]);
        if (incl > TOTAL_CEIL) begin
            r.status = WIS_ST_FULL;
            return r;
        end
        if (incl > 32'(prior)) r.best_total = incl[WIS_TOTAL_W-1:0];
        r.status = WIS_ST_OK;
        sched_finish[sched_count] = job.finish_time;
        sched_total[sched_count]  = r.best_total;
        sched_count = sched_count + 1;
        sched_last  = job.finish_time;
        return r;
    endfunction

    function automatic wis_in_t make_job(input bit first, input logic [31:0] start,
                                         input logic [31:0] finish, input logic [15:0] value);
        wis_in_t j;
        j.first_of_set = first;
        j.start_time   = start;
        j.finish_time  = finish;
        j.job_value    = value;
        return j;
    endfunction

    function automatic demo_row_t demo_row(input bit first, input logic [31:0] start,
                                           input logic [31:0] finish, input logic [15:0] value,
                                           input bit typed, input logic [25:0] total,
                                           input wis_status_t status);
        demo_row_t d;
        d.job             = make_job(first, start, finish, value);
        d.typed           = typed;
        d.want.best_total = total;
        d.want.status     = status;
        return d;
    endfunction

    // Present one job in sender bursts, then log its expected result on transfer
    task automatic offer_job(input wis_in_t job, input bit typed, input wis_out_t want);
        int unsigned gap;
        wis_out_t    predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left = burst_left - 1;
        s_payload <= job;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = schedule_job(job);
        due_results.push_back(typed ? want : predicted);
        jobs_sent = jobs_sent + 1;
    endtask

    // Receiver: mode redrawn whenever rx_tick's low byte wraps; always ready, choppy, or long holds
    int unsigned rx_tick = 0;
    int unsigned rx_hold = 0;
    int unsigned rx_mode = 0;

    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 2) != 0);
                default: begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 11) == 0) rx_hold <= $urandom_range(1, 24);
                end
            endcase
        end
        rx_tick <= rx_tick + 1;
        if (rx_tick[7:0] == 8'hFF) rx_mode <= $urandom_range(0, 2);
    end

    // Compare every result transfer against the oldest expectation
    always @(posedge aclk) begin : check_results
        wis_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: best_total %0d status %0d",
                       m_payload.best_total, m_payload.status);
                fault_count++;
            end else begin
                want = due_results.pop_front();
                if (m_payload.best_total !== want.best_total) begin
                    $error("best_total: expected %0d, got %0d",
                           want.best_total, m_payload.best_total);
                    fault_count++;
                end
                if (m_payload.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_payload.status);
                    fault_count++;
                end
            end
            case (m_payload.status)
                WIS_ST_OK:    ok_seen++;
                WIS_ST_ORDER: order_seen++;
                default:      full_seen++;
            endcase
        end
    end

    initial begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned     left;
        int unsigned     set_len;
        int unsigned     pick;
        int unsigned     step_cap;
        int unsigned     span_cap;
        int unsigned     len;
        logic [31:0]     cur;
        logic [31:0]     fin;
        logic [31:0]     st;
        logic [15:0]     val;
        logic [32:0]     wide;
        bit              first;
        wis_in_t         job;

        // after reset: empty set, then order check
        demo_rows.push_back(demo_row(0, 32'd7, 32'd3, 16'd9, 1, 26'd9, WIS_ST_OK));
        demo_rows.push_back(demo_row(0, 32'd0, 32'd2, 16'd4, 1, 26'd9, WIS_ST_ORDER));
        // new set, zero value and field extremes
        demo_rows.push_back(demo_row(1, 32'd0, 32'd0, 16'd0, 1, 26'd0, WIS_ST_OK));
        demo_rows.push_back(demo_row(0, 32'd0, 32'd0, 16'hFFFF, 0, '0, WIS_ST_OK));
        demo_rows.push_back(demo_row(0, 32'd5, 32'd100, 16'd10, 0, '0, WIS_ST_OK));
        demo_rows.push_back(demo_row(0, 32'd0, 32'd50, 16'd1, 0, '0, WIS_ST_OK));
        demo_rows.push_back(demo_row(0, '1, '1, 16'hFFFF, 0, '0, WIS_ST_OK));
        demo_rows.push_back(demo_row(0, 32'd0, '1, 16'd0, 0, '0, WIS_ST_OK));
        demo_rows.push_back(demo_row(1, '1, '1, 16'hFFFF, 1, 26'd65535, WIS_ST_OK));
        demo_rows.push_back(demo_row(0, 32'd0, 32'd0, 16'd1, 1, 26'd65535, WIS_ST_ORDER));
        // equal finishes: search must land on the last of them
        demo_rows.push_back(demo_row(1, 32'd0, 32'd10, 16'd5, 1, 26'd5, WIS_ST_OK));
        demo_rows.push_back(demo_row(0, 32'd0, 32'd10, 16'd7, 0, '0, WIS_ST_OK));
        demo_rows.push_back(demo_row(0, 32'd0, 32'd10, 16'd3, 0, '0, WIS_ST_OK));
        demo_rows.push_back(demo_row(0, 32'd10, 32'd20, 16'd4, 0, '0, WIS_ST_OK));
        // start before every stored finish, then start equal to one
        demo_rows.push_back(demo_row(0, 32'd5, 32'd30, 16'd100, 0, '0, WIS_ST_OK));
        demo_rows.push_back(demo_row(0, 32'd20, 32'd40, 16'd1, 0, '0, WIS_ST_OK));
        // alternating bit patterns
        demo_rows.push_back(demo_row(0, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 16'hAAAA, 0, '0, WIS_ST_OK));
        demo_rows.push_back(demo_row(0, 32'h5555_5555, 32'h5555_5555, 16'h5555, 0, '0,
                                     WIS_ST_OK));
        demo_rows.push_back(demo_row(1, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 1, 26'h5555,
                                     WIS_ST_OK));
        demo_rows.push_back(demo_row(0, 32'd0, '1, 16'hFFFF, 0, '0, WIS_ST_OK));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (demo_rows[i])
            offer_job(demo_rows[i].job, demo_rows[i].typed, demo_rows[i].want);

        // Random job sets: mostly well-formed, some out-of-order and noise items
        left = RANDOM_JOBS;
        while (left != 0) begin
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 24);
            case ($urandom_range(0, 4))
                0: step_cap = 0;
                1: step_cap = 3;
                2: step_cap = 50;
                3: step_cap = 100000;
                default: step_cap = 32'h0100_0000;
            endcase
            case ($urandom_range(0, 4))
                0: span_cap = 0;
                1: span_cap = 10;
                2: span_cap = 500;
                3: span_cap = 1000000;
                default: span_cap = 32'hFFFF_FFFF;
            endcase
            case ($urandom_range(0, 3))
                0: cur = '0;
                1: cur = $urandom_range(0, 1000);
                2: cur = $urandom;
                default: cur = 32'hFFFF_FF00 | $urandom_range(0, 255);
            endcase
            for (int unsigned n = 0; n < set_len && left != 0; n++) begin
                pick  = $urandom_range(0, 99);
                first = (n == 0);
                case ($urandom_range(0, 15))
                    0: val = '0;
                    1: val = '1;
                    default: val = 16'($urandom);
                endcase
                if (pick < 6 && n != 0 && cur != 0) begin
                    // finish below the last one
                    fin = $urandom_range(0, cur - 1);
                    job = make_job(0, $urandom, fin, val);
                end else if (pick < 10) begin
                    // anything goes
                    job = make_job(1'($urandom_range(0, 1)), $urandom, $urandom,
                                   16'($urandom));
                    if (job.first_of_set) cur = job.finish_time;
                end else begin
                    wide = {1'b0, cur} + {1'b0, 32'($urandom_range(0, step_cap))};
                    fin  = wide[32] ? '1 : wide[31:0];
                    len  = $urandom_range(0, span_cap);
                    st   = (len > fin) ? '0 : fin - len;
                    if ($urandom_range(0, 19) == 0) st = $urandom;
                    job  = make_job(first, st, fin, val);
                    cur  = fin;
                end
                offer_job(job, 0, '0);
                left = left - 1;
            end
        end

        // Close with a fresh one-job set
        offer_job(make_job(1, 32'd0, 32'd5, 16'd1), 1, '{best_total: 26'd1, status: WIS_ST_OK});
        s_valid <= 1'b0;

        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d jobs (%0d directed rows, then random job sets under stalls).",
                 jobs_sent, demo_rows.size());
        $display("Results: %0d accepted, %0d out of order, %0d store full.",
                 ok_seen, order_seen, full_seen);
        if (fault_count == 0 && due_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/wis_pkg.sv
rtl/wis_front.sv
rtl/wis_back.sv
rtl/weighted_interval_scheduling_dp_top.sv
rtl/wis_checker.sv
tb/sv/weighted_interval_scheduling_dp_top_test.sv
